// ----- design/ulaw_n_minus_one_mixer_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the mu-law N-minus-one mixer
// Wrap concurrent assertions so that synthesis sees nothing of them.
// ----------------------------------------------------------------------------
`ifndef ULAW_N_MINUS_ONE_MIXER_MACROS_SVH
`define ULAW_N_MINUS_ONE_MIXER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define ULMIX_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ulmix assertion failed");

// Next-cycle implication
`define ULMIX_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ulmix assertion failed");

`else

`define ULMIX_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ULMIX_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- design/ulmix_pkg.sv -----
// ----------------------------------------------------------------------------
// ulmix_pkg
// Widths, constants and the G.711 mu-law expand/compress functions.
// ----------------------------------------------------------------------------
`default_nettype none

package ulmix_pkg;

   // Lane count and field widths
   localparam int Parties = 7;
   localparam int CodeW   = 8;
   localparam int CountW  = 3;
   localparam int LinW    = 16;
   localparam int SumW    = LinW + $clog2(Parties);

   // Constants of the mu-law code
   localparam logic [LinW-1:0]         Bias    = LinW'(132);
   localparam logic [CodeW-1:0]        Silence = 8'hFF;
   localparam logic signed [LinW-1:0]  LinMax  = 16'sh7FFF;
   localparam logic signed [LinW-1:0]  LinMin  = 16'sh8000;
   localparam logic [CountW-1:0]       ActiveReset = 3'd7;

   typedef logic [CodeW-1:0]        code_type;
   typedef logic signed [LinW-1:0]  lin_type;
   typedef logic signed [SumW-1:0]  sum_type;

   // Expand one mu-law byte to signed linear
   function automatic lin_type ulaw_expand(input code_type code);
      logic [CodeW-1:0] u;
      logic [LinW-1:0]  t;
      lin_type          res;
      u = ~code;
      t = (LinW'({u[3:0], 3'b000}) + Bias) << u[6:4];
      if (u[7]) begin
         res = signed'(Bias - t);
      end else begin
         res = signed'(t - Bias);
      end
      return res;
   endfunction

   // Compress a 16-bit signed linear value to mu-law
   function automatic code_type ulaw_compress(input lin_type x);
      logic [LinW-1:0] mag;
      logic [LinW-1:0] shifted;
      logic [2:0]      seg;
      code_type        mask;
      code_type        res;
      if (x[LinW-1]) begin
         mag  = Bias + (~unsigned'(x) + 1'b1);
         mask = 8'h7F;
      end else begin
         mag  = unsigned'(x) + Bias;
         mask = 8'hFF;
      end
      // Highest set bit above bit 7 picks the segment
      seg = 3'd0;
      for (int s = 1; s < 8; s++) begin
         if (mag[s + 7]) begin
            seg = 3'(s);
         end
      end
      shifted = mag >> (4'(seg) + 4'd3);
      if (mag[LinW-1]) begin
         res = 8'h7F ^ mask;
      end else begin
         res = {1'b0, seg, shifted[3:0]} ^ mask;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- design/ulmix_req_if.sv -----
// ----------------------------------------------------------------------------
// ulmix_req_if
// Input channel: one sample instant, one mu-law byte per party.
// ----------------------------------------------------------------------------
`default_nettype none

interface ulmix_req_if import ulmix_pkg::*; ();
   logic     valid;
   logic     ready;
   code_type party0_code;
   code_type party1_code;
   code_type party2_code;
   code_type party3_code;
   code_type party4_code;
   code_type party5_code;
   code_type party6_code;

   modport source (
      output valid, party0_code, party1_code, party2_code, party3_code,
             party4_code, party5_code, party6_code,
      input  ready
   );
   modport sink (
      input  valid, party0_code, party1_code, party2_code, party3_code,
             party4_code, party5_code, party6_code,
      output ready
   );
endinterface

`default_nettype wire

// ----- design/ulmix_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ulmix_rsp_if
// Result channel: one mu-law mix per party.
// ----------------------------------------------------------------------------
`default_nettype none

interface ulmix_rsp_if import ulmix_pkg::*; ();
   logic     valid;
   logic     ready;
   code_type mix0_code;
   code_type mix1_code;
   code_type mix2_code;
   code_type mix3_code;
   code_type mix4_code;
   code_type mix5_code;
   code_type mix6_code;

   modport source (
      output valid, mix0_code, mix1_code, mix2_code, mix3_code,
             mix4_code, mix5_code, mix6_code,
      input  ready
   );
   modport sink (
      input  valid, mix0_code, mix1_code, mix2_code, mix3_code,
             mix4_code, mix5_code, mix6_code,
      output ready
   );
endinterface

`default_nettype wire

// ----- design/ulmix_csr_if.sv -----
// ----------------------------------------------------------------------------
// ulmix_csr_if
// Configuration write channel for the active party count.
// ----------------------------------------------------------------------------
`default_nettype none

interface ulmix_csr_if import ulmix_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CountW-1:0] active_streams;

   modport source (output valid, active_streams, input ready);
   modport sink   (input valid, active_streams, output ready);
endinterface

`default_nettype wire

// ----- design/ulmix_expand_lane.sv -----
// ----------------------------------------------------------------------------
// ulmix_expand_lane
// Expand one party's mu-law byte to linear; inactive lanes contribute zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ulmix_expand_lane import ulmix_pkg::*; (
   input  wire logic     clock,
   input  wire logic     load,
   input  wire logic     active,
   input  wire code_type code,
   output lin_type       lin,
   output logic          act
);

   lin_type lin_ff, lin_in;
   logic    act_ff;

   // Mask the linear value of an inactive lane
   assign lin_in = active ? ulaw_expand(code) : '0;

   // Capture on item acceptance
   always_ff @(posedge clock) begin
      if (load) begin
         lin_ff <= lin_in;
         act_ff <= active;
      end
   end

   assign lin = lin_ff;
   assign act = act_ff;

endmodule

`default_nettype wire

// ----- design/ulmix_merge.sv -----
// ----------------------------------------------------------------------------
// ulmix_merge
// Sum the linear values of all lanes and carry each lane's own value along.
// ----------------------------------------------------------------------------
`default_nettype none

module ulmix_merge import ulmix_pkg::*; (
   input  wire logic               clock,
   input  wire logic               load,
   input  wire lin_type            lin_i [Parties],
   input  wire logic [Parties-1:0] act_i,
   output sum_type                 sum_o,
   output lin_type                 lin_o [Parties],
   output logic [Parties-1:0]      act_o
);

   sum_type            sum_ff, sum_in;
   lin_type            lin_ff [Parties];
   logic [Parties-1:0] act_ff;

   // Add all lanes; inactive lanes are already zero
   always_comb begin
      sum_in = '0;
      for (int k = 0; k < Parties; k++) begin
         sum_in = sum_in + SumW'(lin_i[k]);
      end
   end

   // Advance the stage
   always_ff @(posedge clock) begin
      if (load) begin
         sum_ff <= sum_in;
         lin_ff <= lin_i;
         act_ff <= act_i;
      end
   end

   assign sum_o = sum_ff;
   assign lin_o = lin_ff;
   assign act_o = act_ff;

endmodule

`default_nettype wire

// ----- design/ulmix_encode_lane.sv -----
// ----------------------------------------------------------------------------
// ulmix_encode_lane
// Remove one party from the sum, saturate to 16 bits and compress to mu-law; inactive lanes give silence.
// ----------------------------------------------------------------------------
`default_nettype none

module ulmix_encode_lane import ulmix_pkg::*; (
   input  wire logic     clock,
   input  wire logic     load,
   input  wire sum_type  sum,
   input  wire lin_type  lin,
   input  wire logic     act,
   output code_type      code
);

   sum_type             diff;
   lin_type             sat;
   logic [SumW-LinW:0]  top_bits;
   code_type            code_ff, code_in;

   // Everyone except this party
   assign diff     = sum - SumW'(lin);
   assign top_bits = diff[SumW-1:LinW-1];

   // Clamp to the signed 16-bit range
   always_comb begin
      if ((&top_bits) || !(|top_bits)) begin
         sat = diff[LinW-1:0];
      end else if (diff[SumW-1]) begin
         sat = LinMin;
      end else begin
         sat = LinMax;
      end
   end

   assign code_in = act ? ulaw_compress(sat) : Silence;

   // Hold the result until the stage advances
   always_ff @(posedge clock) begin
      if (load) begin
         code_ff <= code_in;
      end
   end

   assign code = code_ff;

endmodule

`default_nettype wire

// ----- design/ulaw_n_minus_one_mixer.sv -----
// ----------------------------------------------------------------------------
// ulaw_n_minus_one_mixer: an accepted item passes the expand, sum and encode
// registers to the result. Throughput is one item per cycle while the result
// is not stalled; each stage fills while the result waits. Synchronous reset
// empties the pipeline and sets active_streams to 7.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ulaw_n_minus_one_mixer_macros.svh"

module ulaw_n_minus_one_mixer import ulmix_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   ulmix_req_if.sink   req_chan,
   ulmix_rsp_if.source rsp_chan,
   ulmix_csr_if.sink   csr_chan
);

   logic [CountW-1:0]  active_ff, active_in;
   logic               s1_v_ff, s1_v_in;
   logic               s2_v_ff, s2_v_in;
   logic               s3_v_ff, s3_v_in;
   logic               s1_rdy, s2_rdy, s3_rdy;
   logic               load1, load2, load3;

   code_type           req_code [Parties];
   code_type           mix_code [Parties];
   logic [Parties-1:0] lane_on;
   lin_type            s1_lin [Parties];
   logic [Parties-1:0] s1_act;
   sum_type            s2_sum;
   lin_type            s2_lin [Parties];
   logic [Parties-1:0] s2_act;

   // Configuration register
   assign csr_chan.ready = 1'b1;
   assign active_in = csr_chan.valid ? csr_chan.active_streams : active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ActiveReset;
      end else begin
         active_ff <= active_in;
      end
   end

   // Stage handshake: a stage takes an item when it is empty or drains
   assign s3_rdy = !s3_v_ff || rsp_chan.ready;
   assign s2_rdy = !s2_v_ff || s3_rdy;
   assign s1_rdy = !s1_v_ff || s2_rdy;

   assign load1 = s1_rdy && req_chan.valid;
   assign load2 = s2_rdy && s1_v_ff;
   assign load3 = s3_rdy && s2_v_ff;

   assign s1_v_in = s1_rdy ? req_chan.valid : s1_v_ff;
   assign s2_v_in = s2_rdy ? s1_v_ff : s2_v_ff;
   assign s3_v_in = s3_rdy ? s2_v_ff : s3_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         s3_v_ff <= s3_v_in;
      end
   end

   assign req_chan.ready = s1_rdy;
   assign rsp_chan.valid = s3_v_ff;

   // Gather the input fields into lanes
   assign req_code[0] = req_chan.party0_code;
   assign req_code[1] = req_chan.party1_code;
   assign req_code[2] = req_chan.party2_code;
   assign req_code[3] = req_chan.party3_code;
   assign req_code[4] = req_chan.party4_code;
   assign req_code[5] = req_chan.party5_code;
   assign req_code[6] = req_chan.party6_code;

   // Expand and encode lanes
   for (genvar k = 0; k < Parties; k++) begin : g_lane
      assign lane_on[k] = active_ff > CountW'(k);

      ulmix_expand_lane i_expand (
         .clock  (clock),
         .load   (load1),
         .active (lane_on[k]),
         .code   (req_code[k]),
         .lin    (s1_lin[k]),
         .act    (s1_act[k])
      );

      ulmix_encode_lane i_encode (
         .clock (clock),
         .load  (load3),
         .sum   (s2_sum),
         .lin   (s2_lin[k]),
         .act   (s2_act[k]),
         .code  (mix_code[k])
      );
   end

   ulmix_merge i_merge (
      .clock (clock),
      .load  (load2),
      .lin_i (s1_lin),
      .act_i (s1_act),
      .sum_o (s2_sum),
      .lin_o (s2_lin),
      .act_o (s2_act)
   );

   // Drive the result fields
   assign rsp_chan.mix0_code = mix_code[0];
   assign rsp_chan.mix1_code = mix_code[1];
   assign rsp_chan.mix2_code = mix_code[2];
   assign rsp_chan.mix3_code = mix_code[3];
   assign rsp_chan.mix4_code = mix_code[4];
   assign rsp_chan.mix5_code = mix_code[5];
   assign rsp_chan.mix6_code = mix_code[6];

   // Checks on the stage handoff
   `ULMIX_ASSERT_NEXT(a_accept_fills_s1, clock, reset, req_chan.valid && s1_rdy, s1_v_ff)
   `ULMIX_ASSERT_NEXT(a_s2_holds_sum, clock, reset, s2_v_ff && !s3_rdy, s2_v_ff && $stable(s2_sum))
   `ULMIX_ASSERT_NEXT(a_s2_to_rsp, clock, reset, s2_v_ff && s3_rdy, rsp_chan.valid)

endmodule

`default_nettype wire
